### hw/rtl/frdr_pkg.sv
// ----------------------------------------------------------------------------
// frdr_pkg
// Shared widths and constants for the Fresnel reflectance pipeline.
// ----------------------------------------------------------------------------
package frdr_pkg;

    localparam int MAG_W    = 17;
    localparam int IDX_W    = 16;
    localparam int SIN_W    = 31;
    localparam int ROOT_W   = 16;
    localparam int SQREM_W  = 18;
    localparam int SQIN_W   = 32;
    localparam int X_W      = 30;
    localparam int RDEN_W   = 32;
    localparam int RQ_W     = 25;
    localparam int RSTEPS   = 24;

    localparam logic [SIN_W-1:0]  ONE_Q30   = SIN_W'(1) << 30;
    localparam logic [IDX_W-1:0]  IDX_RESET = 16'd6144;

endpackage

### hw/rtl/fresnel_dielectric_reflectance.sv
// ----------------------------------------------------------------------------
// fresnel_dielectric_reflectance
// Unpolarized Fresnel reflectance of a smooth dielectric boundary.
// ----------------------------------------------------------------------------
// Slave stream: one beat carries cos_incident (signed Q1.15) in tdata.
// Master stream: one beat per input beat, reflectance (Q0.16) in tdata,
// total internal reflection flag in tuser.
// Config channel: writes the relative index (unsigned Q4.12); zero acts as one LSB (2^-12).
// Write it only while the pipeline is empty.
// Throughput: one beat per cycle while the receiver does not stall. The path is a
// chain of 30 divider cells (Snell), 16 square-root cells and 24 ratio divider cells,
// plus the multiply and output stages.
// The whole pipeline advances together; when the receiver stalls with a
// result held in the output register, every stage holds and s_axis_tready
// drops. Reset clears all valid bits and loads the index with 1.5.
// ----------------------------------------------------------------------------
module fresnel_dielectric_reflectance import frdr_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [15:0] cos_incident
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [15:0] reflectance
    output logic [0:0]  m_axis_tuser,   // [0] total_internal_reflection
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_cfg_data
);

    localparam int DPAY_W = 2 + X_W + MAG_W + IDX_W;
    localparam int SPAY_W = 1 + MAG_W + IDX_W;

    logic en;
    logic [IDX_W-1:0] r_index;

    // stage A
    logic             r_a_valid;
    logic             r_a_rev;
    logic [MAG_W-1:0] r_a_mag;
    logic [IDX_W-1:0] r_a_e;
    // stage B
    logic             r_b_valid;
    logic             r_b_rev;
    logic [MAG_W-1:0] r_b_mag;
    logic [IDX_W-1:0] r_b_e;
    logic [SIN_W-1:0] r_b_s;
    logic [31:0]      r_b_e2;
    // stage C
    logic             r_c_valid;
    logic             r_c_rev;
    logic [MAG_W-1:0] r_c_mag;
    logic [IDX_W-1:0] r_c_e;
    logic [SIN_W-1:0] r_c_s;
    logic [31:0]      r_c_e2;
    logic [62:0]      r_c_prod;

    logic [2*MAG_W-1:0] mag_sq;
    logic [MAG_W-1:0]   in_mag;
    logic               c_tir;
    logic [37:0]        e2_shift;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_index <= IDX_RESET;
        end else if (i_cfg_valid) begin
            r_index <= i_cfg_data;
        end
    end
    assign o_cfg_ready = 1'b1;

    assign en            = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = en;

    assign in_mag = s_axis_tdata[15] ? MAG_W'(16'(~s_axis_tdata + 16'd1))
                                     : MAG_W'(s_axis_tdata);
    assign mag_sq = r_a_mag * r_a_mag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
        end else if (en) begin
            r_a_valid <= s_axis_tvalid;
            r_b_valid <= r_a_valid;
            r_c_valid <= r_b_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a_rev    <= s_axis_tdata[15];
            r_a_mag    <= in_mag;
            r_a_e      <= (r_index == '0) ? IDX_W'(1) : r_index;
            r_b_rev    <= r_a_rev;
            r_b_mag    <= r_a_mag;
            r_b_e      <= r_a_e;
            r_b_s      <= ONE_Q30 - mag_sq[SIN_W-1:0];
            r_b_e2     <= r_a_e * r_a_e;
            r_c_rev    <= r_b_rev;
            r_c_mag    <= r_b_mag;
            r_c_e      <= r_b_e;
            r_c_s      <= r_b_s;
            r_c_e2     <= r_b_e2;
            r_c_prod   <= r_b_s * r_b_e2;
        end
    end

    assign e2_shift = {r_c_e2, 6'b0};
    assign c_tir = r_c_rev ? (r_c_prod[62:54] != '0)
                           : (38'(r_c_s) >= e2_shift);

    // Snell divider chain: X = S * 2^24 / e^2
    logic              d_valid [0:X_W];
    logic [31:0]       d_rem   [0:X_W];
    logic [31:0]       d_div   [0:X_W];
    logic [X_W-1:0]    d_quo   [0:X_W];
    logic [X_W-1:0]    d_low   [0:X_W];
    logic [DPAY_W-1:0] d_pay   [0:X_W];

    assign d_valid[0] = r_c_valid;
    assign d_rem[0]   = 32'(r_c_s[SIN_W-1:6]);
    assign d_div[0]   = r_c_e2;
    assign d_quo[0]   = '0;
    assign d_low[0]   = {r_c_s[5:0], 24'b0};
    assign d_pay[0]   = {r_c_rev, c_tir, r_c_prod[53:24], r_c_mag, r_c_e};

    for (genvar g = 0; g < X_W; g++) begin : g_div
        frdr_div_cell #(.DW(32), .QW(X_W), .LW(X_W), .PW(DPAY_W)) u_cell (
            .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en),
            .i_valid(d_valid[g]), .i_rem(d_rem[g]), .i_div(d_div[g]),
            .i_quo(d_quo[g]), .i_low(d_low[g]), .i_pay(d_pay[g]),
            .o_valid(d_valid[g+1]), .o_rem(d_rem[g+1]), .o_div(d_div[g+1]),
            .o_quo(d_quo[g+1]), .o_low(d_low[g+1]), .o_pay(d_pay[g+1])
        );
    end

    logic             dx_rev;
    logic             dx_tir;
    logic [X_W-1:0]   dx_exit;
    logic [MAG_W-1:0] dx_mag;
    logic [IDX_W-1:0] dx_e;
    logic [X_W-1:0]   dx_x;

    assign {dx_rev, dx_tir, dx_exit, dx_mag, dx_e} = d_pay[X_W];
    assign dx_x = dx_rev ? dx_exit : d_quo[X_W];

    // square root chain: ct = floor(sqrt(2^30 - X))
    logic               q_valid [0:ROOT_W];
    logic [SQREM_W-1:0] q_rem   [0:ROOT_W];
    logic [ROOT_W-1:0]  q_root  [0:ROOT_W];
    logic [SQIN_W-1:0]  q_rad   [0:ROOT_W];
    logic [SPAY_W-1:0]  q_pay   [0:ROOT_W];

    assign q_valid[0] = d_valid[X_W];
    assign q_rem[0]   = '0;
    assign q_root[0]  = '0;
    assign q_rad[0]   = SQIN_W'(ONE_Q30 - SIN_W'(dx_x));
    assign q_pay[0]   = {dx_tir, dx_mag, dx_e};

    for (genvar g = 0; g < ROOT_W; g++) begin : g_sqrt
        frdr_sqrt_cell #(.PW(SPAY_W)) u_cell (
            .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en),
            .i_valid(q_valid[g]), .i_rem(q_rem[g]), .i_root(q_root[g]),
            .i_rad(q_rad[g]), .i_pay(q_pay[g]),
            .o_valid(q_valid[g+1]), .o_rem(q_rem[g+1]), .o_root(q_root[g+1]),
            .o_rad(q_rad[g+1]), .o_pay(q_pay[g+1])
        );
    end

    logic             qx_tir;
    logic [MAG_W-1:0] qx_mag;
    logic [IDX_W-1:0] qx_e;
    assign {qx_tir, qx_mag, qx_e} = q_pay[ROOT_W];

    // stage E: cross products
    logic              r_e_valid;
    logic              r_e_tir;
    logic [RDEN_W-1:0] r_e_ec;
    logic [RDEN_W-1:0] r_e_et;
    logic [RDEN_W-1:0] r_e_kt;
    logic [RDEN_W-1:0] r_e_kc;
    logic [MAG_W+IDX_W-1:0] ec_full;
    logic [ROOT_W+IDX_W-1:0] et_full;

    assign ec_full = qx_mag * qx_e;
    assign et_full = q_root[ROOT_W] * qx_e;

    // stage F: numerators and denominators
    logic              r_f_valid;
    logic              r_f_tir;
    logic [RDEN_W-1:0] r_f_na;
    logic [RDEN_W-1:0] r_f_da;
    logic [RDEN_W-1:0] r_f_nb;
    logic [RDEN_W-1:0] r_f_db;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_valid <= 1'b0;
            r_f_valid <= 1'b0;
        end else if (en) begin
            r_e_valid <= q_valid[ROOT_W];
            r_f_valid <= r_e_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_e_tir <= qx_tir;
            r_e_ec  <= ec_full[RDEN_W-1:0];
            r_e_et  <= et_full;
            r_e_kt  <= RDEN_W'({q_root[ROOT_W], 12'b0});
            r_e_kc  <= RDEN_W'({qx_mag, 12'b0});
            r_f_tir <= r_e_tir;
            r_f_na  <= (r_e_ec >= r_e_kt) ? r_e_ec - r_e_kt : r_e_kt - r_e_ec;
            r_f_da  <= r_e_ec + r_e_kt;
            r_f_nb  <= (r_e_kc >= r_e_et) ? r_e_kc - r_e_et : r_e_et - r_e_kc;
            r_f_db  <= r_e_kc + r_e_et;
        end
    end

    // ratio divider lanes: a = |numA| * 2^24 / denA, b likewise
    logic              ra_valid [0:RSTEPS];
    logic [RDEN_W-1:0] ra_rem   [0:RSTEPS];
    logic [RDEN_W-1:0] ra_div   [0:RSTEPS];
    logic [RQ_W-1:0]   ra_quo   [0:RSTEPS];
    logic [1:0]        ra_low   [0:RSTEPS];
    logic [0:0]        ra_pay   [0:RSTEPS];
    logic              rb_valid [0:RSTEPS];
    logic [RDEN_W-1:0] rb_rem   [0:RSTEPS];
    logic [RDEN_W-1:0] rb_div   [0:RSTEPS];
    logic [RQ_W-1:0]   rb_quo   [0:RSTEPS];
    logic [1:0]        rb_low   [0:RSTEPS];
    logic [0:0]        rb_pay   [0:RSTEPS];

    logic [RDEN_W-1:0] da0;
    logic [RDEN_W-1:0] db0;
    logic              ga;
    logic              gb;

    assign da0 = (r_f_da == '0) ? RDEN_W'(1) : r_f_da;
    assign db0 = (r_f_db == '0) ? RDEN_W'(1) : r_f_db;
    assign ga  = (r_f_na >= r_f_da);
    assign gb  = (r_f_nb >= r_f_db);

    assign ra_valid[0] = r_f_valid;
    assign ra_rem[0]   = ga ? r_f_na - r_f_da : r_f_na;
    assign ra_div[0]   = da0;
    assign ra_quo[0]   = RQ_W'(ga);
    assign ra_low[0]   = '0;
    assign ra_pay[0]   = r_f_tir;
    assign rb_valid[0] = r_f_valid;
    assign rb_rem[0]   = gb ? r_f_nb - r_f_db : r_f_nb;
    assign rb_div[0]   = db0;
    assign rb_quo[0]   = RQ_W'(gb);
    assign rb_low[0]   = '0;
    assign rb_pay[0]   = r_f_tir;

    for (genvar g = 0; g < RSTEPS; g++) begin : g_ratio
        frdr_div_cell #(.DW(RDEN_W), .QW(RQ_W), .LW(2), .PW(1)) u_cell_a (
            .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en),
            .i_valid(ra_valid[g]), .i_rem(ra_rem[g]), .i_div(ra_div[g]),
            .i_quo(ra_quo[g]), .i_low(ra_low[g]), .i_pay(ra_pay[g]),
            .o_valid(ra_valid[g+1]), .o_rem(ra_rem[g+1]), .o_div(ra_div[g+1]),
            .o_quo(ra_quo[g+1]), .o_low(ra_low[g+1]), .o_pay(ra_pay[g+1])
        );
        frdr_div_cell #(.DW(RDEN_W), .QW(RQ_W), .LW(2), .PW(1)) u_cell_b (
            .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en),
            .i_valid(rb_valid[g]), .i_rem(rb_rem[g]), .i_div(rb_div[g]),
            .i_quo(rb_quo[g]), .i_low(rb_low[g]), .i_pay(rb_pay[g]),
            .o_valid(rb_valid[g+1]), .o_rem(rb_rem[g+1]), .o_div(rb_div[g+1]),
            .o_quo(rb_quo[g+1]), .o_low(rb_low[g+1]), .o_pay(rb_pay[g+1])
        );
    end

    // stage G: squares, stage H: output register
    logic                r_g_valid;
    logic                r_g_tir;
    logic [2*RQ_W-1:0]   r_g_asq;
    logic [2*RQ_W-1:0]   r_g_bsq;
    logic [2*RQ_W:0]     sum;
    logic [2*RQ_W-33:0]  rsh;
    logic [15:0]         refl;

    logic                r_o_valid;
    logic [15:0]         r_o_refl;
    logic                r_o_tir;

    assign sum  = (2*RQ_W+1)'(r_g_asq) + (2*RQ_W+1)'(r_g_bsq)
                + ((2*RQ_W+1)'(1) << 32);
    assign rsh  = sum[2*RQ_W:33];
    assign refl = r_g_tir ? 16'hFFFF
                : ((rsh > (2*RQ_W-32)'(16'hFFFF)) ? 16'hFFFF : rsh[15:0]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_g_valid <= 1'b0;
            r_o_valid <= 1'b0;
        end else if (en) begin
            r_g_valid <= ra_valid[RSTEPS] & rb_valid[RSTEPS];
            r_o_valid <= r_g_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_g_tir  <= ra_pay[RSTEPS][0] | rb_pay[RSTEPS][0];
            r_g_asq  <= ra_quo[RSTEPS] * ra_quo[RSTEPS];
            r_g_bsq  <= rb_quo[RSTEPS] * rb_quo[RSTEPS];
            r_o_refl <= refl;
            r_o_tir  <= r_g_tir;
        end
    end

    assign m_axis_tvalid   = r_o_valid;
    assign m_axis_tdata    = r_o_refl;
    assign m_axis_tuser[0] = r_o_tir;

endmodule

### hw/rtl/frdr_div_cell.sv
// ----------------------------------------------------------------------------
// frdr_div_cell
// One restoring divide step: one quotient bit per cell, registered.
// ----------------------------------------------------------------------------
module frdr_div_cell #(
    parameter int DW = 32,
    parameter int QW = 30,
    parameter int LW = 30,
    parameter int PW = 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  logic [DW-1:0] i_rem,
    input  logic [DW-1:0] i_div,
    input  logic [QW-1:0] i_quo,
    input  logic [LW-1:0] i_low,
    input  logic [PW-1:0] i_pay,
    output logic          o_valid,
    output logic [DW-1:0] o_rem,
    output logic [DW-1:0] o_div,
    output logic [QW-1:0] o_quo,
    output logic [LW-1:0] o_low,
    output logic [PW-1:0] o_pay
);

    logic [DW:0]   t;
    logic [DW:0]   diff;
    logic          ge;
    logic [DW-1:0] n_rem;

    logic          r_valid;
    logic [DW-1:0] r_rem;
    logic [DW-1:0] r_div;
    logic [QW-1:0] r_quo;
    logic [LW-1:0] r_low;
    logic [PW-1:0] r_pay;

    always_comb begin
        t     = {i_rem, i_low[LW-1]};
        diff  = t - {1'b0, i_div};
        ge    = (t >= {1'b0, i_div});
        n_rem = ge ? diff[DW-1:0] : t[DW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem <= n_rem;
            r_div <= i_div;
            r_quo <= {i_quo[QW-2:0], ge};
            r_low <= {i_low[LW-2:0], 1'b0};
            r_pay <= i_pay;
        end
    end

    assign o_valid = r_valid;
    assign o_rem   = r_rem;
    assign o_div   = r_div;
    assign o_quo   = r_quo;
    assign o_low   = r_low;
    assign o_pay   = r_pay;

endmodule

### hw/rtl/frdr_sqrt_cell.sv
// ----------------------------------------------------------------------------
// frdr_sqrt_cell
// One digit-by-digit square root step: one root bit per cell, registered.
// ----------------------------------------------------------------------------
module frdr_sqrt_cell import frdr_pkg::*; #(
    parameter int PW = 1
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_valid,
    input  logic [SQREM_W-1:0] i_rem,
    input  logic [ROOT_W-1:0]  i_root,
    input  logic [SQIN_W-1:0]  i_rad,
    input  logic [PW-1:0]      i_pay,
    output logic               o_valid,
    output logic [SQREM_W-1:0] o_rem,
    output logic [ROOT_W-1:0]  o_root,
    output logic [SQIN_W-1:0]  o_rad,
    output logic [PW-1:0]      o_pay
);

    logic [SQREM_W+1:0] t;
    logic [SQREM_W+1:0] trial;
    logic [SQREM_W+1:0] diff;
    logic               ge;

    logic               r_valid;
    logic [SQREM_W-1:0] r_rem;
    logic [ROOT_W-1:0]  r_root;
    logic [SQIN_W-1:0]  r_rad;
    logic [PW-1:0]      r_pay;

    always_comb begin
        t     = {i_rem, i_rad[SQIN_W-1 -: 2]};
        trial = (SQREM_W+2)'({i_root, 2'b01});
        diff  = t - trial;
        ge    = (t >= trial);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem  <= ge ? diff[SQREM_W-1:0] : t[SQREM_W-1:0];
            r_root <= {i_root[ROOT_W-2:0], ge};
            r_rad  <= {i_rad[SQIN_W-3:0], 2'b00};
            r_pay  <= i_pay;
        end
    end

    assign o_valid = r_valid;
    assign o_rem   = r_rem;
    assign o_root  = r_root;
    assign o_rad   = r_rad;
    assign o_pay   = r_pay;

endmodule
